/* rtl/jog_pkg.sv */
// ----------------------------------------------------------------------------
// jog_pkg
// Shared types and constants of the jitter offset generator.
// ----------------------------------------------------------------------------
`default_nettype none

package jog_pkg;

  localparam int unsigned TS_W        = 64;
  localparam int unsigned CFG_W       = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned JIT_W       = 15;
  localparam int unsigned RANGE_W     = JIT_W + 1;
  localparam int unsigned OFS_W       = 16;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned DRAW_W      = 15;
  localparam int unsigned DRAW_LSB    = 16;
  localparam int unsigned DIV_STAGES  = TS_W;
  localparam int unsigned REM_STAGES  = DRAW_W;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [WORD_W-1:0] LCG_MUL  = 32'd214013;
  localparam logic [WORD_W-1:0] LCG_INC  = 32'd2531011;
  localparam logic [WORD_W-1:0] SEED_MUL = 32'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT   = 3'd0,
    CFG_RIGHT  = 3'd1,
    CFG_UP     = 3'd2,
    CFG_DOWN   = 3'd3,
    CFG_PERIOD = 3'd4,
    CFG_SEED   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [JIT_W-1:0]  left;
    logic [JIT_W-1:0]  right;
    logic [JIT_W-1:0]  up;
    logic [JIT_W-1:0]  down;
    logic [WORD_W-1:0] period;
    logic [WORD_W-1:0] seed;
  } cfg_t;

  typedef struct packed {
    logic [TS_W-1:0] mag;
    logic            neg;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

`default_nettype wire

/* rtl/jog_front.sv */
// ----------------------------------------------------------------------------
// jog_front
// Input stage: takes a timestamp and splits it into sign and magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module jog_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [jog_pkg::TS_W-1:0]   timestamp_i,
  input  wire logic                              q_full_i,
  output logic                                   push_o,
  output jog_pkg::entry_t                        entry_o
);

  logic            valid_q;
  jog_pkg::entry_t entry_q;
  logic            load;

  assign in_stall_o = valid_q && q_full_i;
  assign push_o     = valid_q && !q_full_i;
  assign load       = !valid_q || push_o;
  assign entry_o    = entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      entry_q.neg <= timestamp_i[jog_pkg::TS_W-1];
      entry_q.mag <= timestamp_i[jog_pkg::TS_W-1] ? (~timestamp_i + 1'b1) : timestamp_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/jog_queue.sv */
// ----------------------------------------------------------------------------
// jog_queue
// Short first-in first-out queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module jog_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  jog_pkg::entry_t      entry_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output jog_pkg::head_t       head_o
);

  jog_pkg::entry_t                   mem_q [jog_pkg::QUEUE_DEPTH];
  logic [jog_pkg::QPTR_W-1:0]        wr_ptr_q, rd_ptr_q;
  logic [jog_pkg::QCNT_W-1:0]        cnt_q;
  logic                              do_pop;

  assign full_o       = (cnt_q == jog_pkg::QCNT_W'(jog_pkg::QUEUE_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  function automatic logic [jog_pkg::QPTR_W-1:0] ptr_inc(input logic [jog_pkg::QPTR_W-1:0] p);
    return (p == jog_pkg::QPTR_W'(jog_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/jog_div.sv */
// ----------------------------------------------------------------------------
// jog_div
// Pipelined restoring divider: 64-bit magnitude by 32-bit divisor,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module jog_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         in_valid_i,
  input  jog_pkg::entry_t                   entry_i,
  input  wire logic [jog_pkg::WORD_W-1:0]   divisor_i,
  output logic                              out_valid_o,
  output logic                              out_neg_o,
  output logic [jog_pkg::WORD_W-1:0]        quot_o
);

  localparam int unsigned N = jog_pkg::DIV_STAGES;
  localparam int unsigned W = jog_pkg::WORD_W;
  localparam int unsigned T = jog_pkg::TS_W;

  logic         valid_q [N];
  logic         neg_q   [N];
  logic [W-1:0] rem_q   [N];
  logic [T-1:0] word_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic         p_valid, p_neg;
    logic [W-1:0] p_rem;
    logic [T-1:0] p_word;
    logic [W:0]   trial;
    logic [W+1:0] diff;
    logic         ge;

    if (k == 0) begin : g_first
      assign p_valid = in_valid_i;
      assign p_neg   = entry_i.neg;
      assign p_rem   = '0;
      assign p_word  = entry_i.mag;
    end else begin : g_next
      assign p_valid = valid_q[k-1];
      assign p_neg   = neg_q[k-1];
      assign p_rem   = rem_q[k-1];
      assign p_word  = word_q[k-1];
    end

    assign trial = {p_rem, p_word[T-1]};
    assign diff  = {1'b0, trial} - {2'b00, divisor_i};
    assign ge    = !diff[W+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= p_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[k]  <= p_neg;
        rem_q[k]  <= ge ? diff[W-1:0] : trial[W-1:0];
        word_q[k] <= {p_word[T-2:0], ge};
      end
    end
  end

  assign out_valid_o = valid_q[N-1];
  assign out_neg_o   = neg_q[N-1];
  assign quot_o      = word_q[N-1][W-1:0];

endmodule

`default_nettype wire

/* rtl/jog_urem.sv */
// ----------------------------------------------------------------------------
// jog_urem
// Pipelined remainder of a 15-bit draw by a 16-bit range,
// one dividend bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module jog_urem (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          in_valid_i,
  input  wire logic [jog_pkg::DRAW_W-1:0]    draw_i,
  input  wire logic [jog_pkg::RANGE_W-1:0]   range_i,
  output logic                               out_valid_o,
  output logic [jog_pkg::RANGE_W-1:0]        rem_o
);

  localparam int unsigned N = jog_pkg::REM_STAGES;
  localparam int unsigned R = jog_pkg::RANGE_W;
  localparam int unsigned D = jog_pkg::DRAW_W;

  logic         valid_q [N];
  logic [R-1:0] rem_q   [N];
  logic [D-1:0] word_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic         p_valid;
    logic [R-1:0] p_rem;
    logic [D-1:0] p_word;
    logic [R:0]   trial;
    logic [R+1:0] diff;
    logic         ge;

    if (k == 0) begin : g_first
      assign p_valid = in_valid_i;
      assign p_rem   = '0;
      assign p_word  = draw_i;
    end else begin : g_next
      assign p_valid = valid_q[k-1];
      assign p_rem   = rem_q[k-1];
      assign p_word  = word_q[k-1];
    end

    assign trial = {p_rem, p_word[D-1]};
    assign diff  = {1'b0, trial} - {2'b00, range_i};
    assign ge    = !diff[R+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= p_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[R-1:0] : trial[R-1:0];
        word_q[k] <= {p_word[D-2:0], 1'b0};
      end
    end
  end

  assign out_valid_o = valid_q[N-1];
  assign rem_o       = rem_q[N-1];

endmodule

`default_nettype wire

/* rtl/jog_back.sv */
// ----------------------------------------------------------------------------
// jog_back
// Back end: period division, frame seed, two generator steps, range
// reduction and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jog_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  jog_pkg::cfg_t                          cfg_i,
  input  jog_pkg::head_t                         head_i,
  output logic                                   pop_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [jog_pkg::OFS_W-1:0]       offset_x_o,
  output logic signed [jog_pkg::OFS_W-1:0]       offset_y_o
);

  localparam int unsigned W = jog_pkg::WORD_W;
  localparam int unsigned R = jog_pkg::RANGE_W;
  localparam int unsigned D = jog_pkg::DRAW_W;
  localparam int unsigned L = jog_pkg::DRAW_LSB;

  logic         en;
  logic [W-1:0] divisor;
  logic [R-1:0] range_x, range_y;

  logic         div_valid, div_neg;
  logic [W-1:0] quot, quot_s;

  logic         a_valid_q, b_valid_q, c_valid_q, d_valid_q;
  logic [W-1:0] sa_q, sb_q, s1_q, s2_q;
  logic [D-1:0] draw1_q;
  logic [D-1:0] draw_y;

  logic         rx_valid, ry_valid;
  logic [R-1:0] rem_x, rem_y;

  logic                    out_valid_q;
  logic [jog_pkg::OFS_W-1:0] x_q, y_q;

  assign en      = !out_valid_q || !out_stall_i;
  assign pop_o   = en && head_i.valid;
  assign divisor = (cfg_i.period == '0) ? W'(1) : cfg_i.period;
  assign range_x = {1'b0, cfg_i.left} + {1'b0, cfg_i.right};
  assign range_y = {1'b0, cfg_i.up} + {1'b0, cfg_i.down};

  jog_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (head_i.valid),
    .entry_i     (head_i.entry),
    .divisor_i   (divisor),
    .out_valid_o (div_valid),
    .out_neg_o   (div_neg),
    .quot_o      (quot)
  );

  assign quot_s = div_neg ? (~quot + 1'b1) : quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= div_valid;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q    <= cfg_i.seed + quot_s;
      sb_q    <= W'(sa_q * jog_pkg::SEED_MUL);
      s1_q    <= W'(sb_q * jog_pkg::LCG_MUL) + jog_pkg::LCG_INC;
      s2_q    <= W'(s1_q * jog_pkg::LCG_MUL) + jog_pkg::LCG_INC;
      draw1_q <= s1_q[L+D-1:L];
    end
  end

  // an empty x range consumes no draw
  assign draw_y = (range_x != '0) ? s2_q[L+D-1:L] : draw1_q;

  jog_urem u_rem_x (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (d_valid_q),
    .draw_i      (draw1_q),
    .range_i     (range_x),
    .out_valid_o (rx_valid),
    .rem_o       (rem_x)
  );

  jog_urem u_rem_y (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (d_valid_q),
    .draw_i      (draw_y),
    .range_i     (range_y),
    .out_valid_o (ry_valid),
    .rem_o       (rem_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= rx_valid && ry_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q <= (range_x != '0) ? (rem_x - {1'b0, cfg_i.left}) : '0;
      y_q <= (range_y != '0) ? (rem_y - {1'b0, cfg_i.up}) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign offset_x_o  = x_q;
  assign offset_y_o  = y_q;

endmodule

`default_nettype wire

/* rtl/jitter_offset_generator.sv */
// ----------------------------------------------------------------------------
// jitter_offset_generator
// Per-frame pseudo-random x/y jitter offset from a presentation timestamp.
//
// Input channel: in_valid_i / in_stall_o with timestamp_i; output channel:
// out_valid_o / out_stall_i with offset_x_o and offset_y_o. A transfer
// happens at a rising edge with valid high and stall low.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 left, 1 right, 2 up, 3 down, 4 period, 5 seed); write only while idle.
// Path from input transfer to output valid: one front stage, one queue
// slot, 64 divider stages (one quotient bit per stage), four seed/generator
// stages, 15 remainder stages and the output register. One item per cycle
// enters and leaves while the receiver does not stall.
// When the receiver stalls, the back pipeline holds, the queue fills and
// then in_stall_o rises. Reset empties all stages and the queue and loads
// the register reset values (period 1, all others 0); no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module jitter_offset_generator (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic signed [jog_pkg::TS_W-1:0]       timestamp_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic signed [jog_pkg::OFS_W-1:0]           offset_x_o,
  output logic signed [jog_pkg::OFS_W-1:0]           offset_y_o,
  input  wire logic                                  cfg_we_i,
  input  wire logic [jog_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [jog_pkg::CFG_W-1:0]             cfg_wdata_i
);

  jog_pkg::cfg_t   cfg_q;
  jog_pkg::entry_t front_entry;
  jog_pkg::head_t  head;
  logic            push, q_full, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{left: '0, right: '0, up: '0, down: '0,
                 period: jog_pkg::WORD_W'(1), seed: '0};
    end else if (cfg_we_i) begin
      unique case (jog_pkg::cfg_idx_e'(cfg_idx_i))
        jog_pkg::CFG_LEFT:   cfg_q.left   <= cfg_wdata_i[jog_pkg::JIT_W-1:0];
        jog_pkg::CFG_RIGHT:  cfg_q.right  <= cfg_wdata_i[jog_pkg::JIT_W-1:0];
        jog_pkg::CFG_UP:     cfg_q.up     <= cfg_wdata_i[jog_pkg::JIT_W-1:0];
        jog_pkg::CFG_DOWN:   cfg_q.down   <= cfg_wdata_i[jog_pkg::JIT_W-1:0];
        jog_pkg::CFG_PERIOD: cfg_q.period <= cfg_wdata_i[jog_pkg::WORD_W-1:0];
        jog_pkg::CFG_SEED:   cfg_q.seed   <= cfg_wdata_i[jog_pkg::WORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  jog_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .timestamp_i (timestamp_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .entry_o     (front_entry)
  );

  jog_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .head_o  (head)
  );

  jog_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .offset_x_o  (offset_x_o),
    .offset_y_o  (offset_y_o)
  );

endmodule

`default_nettype wire

/* rtl/jog_checker.sv */
// ----------------------------------------------------------------------------
// jog_checker
// Port-level checks of the jitter offset generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module jog_checker (
  input wire logic                                  clk_i,
  input wire logic                                  rst_ni,
  input wire logic                                  in_stall_o,
  input wire logic                                  out_valid_o,
  input wire logic                                  out_stall_i,
  input wire logic signed [jog_pkg::OFS_W-1:0]      offset_x_o,
  input wire logic signed [jog_pkg::OFS_W-1:0]      offset_y_o
);

  localparam logic [jog_pkg::OFS_W-1:0] OFS_MIN = {1'b1, {(jog_pkg::OFS_W-1){1'b0}}};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(offset_x_o) && $stable(offset_y_o))
    else $error("output changed while stalled");

  a_empty_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("pipeline not empty after reset");

  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> offset_x_o != OFS_MIN)
    else $error("offset_x out of range");

  a_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> offset_y_o != OFS_MIN)
    else $error("offset_y out of range");

endmodule

bind jitter_offset_generator jog_checker u_jog_checker (.*);

`default_nettype wire
